[design/lcg_brg_pkg.sv]
// ----------------------------------------------------------------------------
// lcg_brg_pkg
// shared types, codes and helpers of the bounded-range generator
// ----------------------------------------------------------------------------
package lcg_brg_pkg;

	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;

	typedef enum logic [1:0] {
		CMD_RESTART = 2'd0,
		CMD_RAW     = 2'd1,
		CMD_RANGE   = 2'd2,
		CMD_CHANCE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		W8  = 2'd0,
		W16 = 2'd1,
		W32 = 2'd2,
		W64 = 2'd3
	} width_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  width_sel;
		logic        is_signed;
		logic [63:0] low_value;
		logic [63:0] high_value;
		logic [63:0] chance_n;
	} in_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic        chance_hit;
		logic        range_swapped;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_BOUND,
		ST_RAW_A,
		ST_RAW_B,
		ST_THR,
		ST_THR_WAIT,
		ST_DRAW_A,
		ST_DRAW_B,
		ST_CHECK,
		ST_MOD_WAIT,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic setup;
		logic bound;
		logic restart;
		logic draw_first;
		logic draw_second;
		logic div_thr;
		logic div_mod;
		logic out_load;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic is64;
		logic full;
		logic nzero;
		logic div_busy;
		logic v_ge_thr;
		logic out_free;
	} stat_t;

	function automatic logic [63:0] width_mask(input logic [1:0] w);
		logic [63:0] m;
		case (w)
			W8:      m = 64'h0000_0000_0000_00FF;
			W16:     m = 64'h0000_0000_0000_FFFF;
			W32:     m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] sign_bit(input logic [1:0] w);
		logic [63:0] s;
		case (w)
			W8:      s = 64'h0000_0000_0000_0080;
			W16:     s = 64'h0000_0000_0000_8000;
			W32:     s = 64'h0000_0000_8000_0000;
			default: s = 64'h8000_0000_0000_0000;
		endcase
		return s;
	endfunction

endpackage

[design/lcg_brg_datapath.sv]
// ----------------------------------------------------------------------------
// lcg_brg_datapath
// generator state, bound set-up, bit-serial divider and output register
// ----------------------------------------------------------------------------
module lcg_brg_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcg_brg_pkg::ctrl_t    ctrl,
	output lcg_brg_pkg::stat_t    stat,
	input  lcg_brg_pkg::in_item_t in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lcg_brg_pkg::out_item_t out_item,
	input  logic                  cfg_we,
	input  logic [31:0]           cfg_wdata
);
	import lcg_brg_pkg::*;

	localparam int DW = 64;
	localparam logic [6:0] DIV_STEPS = 7'(DW);

	logic [31:0] seed_q, gen_q, step;
	cmd_t        cmd_q;
	logic [1:0]  width_q;
	logic [63:0] flip_q, lo_q, hi_q, span_q, bound_q, v_q;
	logic        swapped_q, full_q, nzero_q;
	logic [63:0] rem_q, dvd_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial, diff;
	logic [63:0] mask_in, flip_in, neg_bound, res_value;
	logic        is64, full;
	logic        out_valid_q;
	out_item_t   out_q;

	assign step = gen_q * LCG_MUL + LCG_ADD;

	assign mask_in = width_mask(in_item.width_sel);
	assign flip_in = (cmd_t'(in_item.cmd) == CMD_RANGE && in_item.is_signed)
		? sign_bit(in_item.width_sel) : 64'd0;

	assign is64 = (width_q == W64) || (cmd_q == CMD_CHANCE);
	assign full = (width_q == W64 && (&span_q)) ||
		(width_q == W32 && span_q == 64'h0000_0000_FFFF_FFFF);
	assign neg_bound = 64'd0 - bound_q;

	// seed and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			gen_q  <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
			gen_q  <= cfg_wdata;
		end else if (ctrl.restart) begin
			gen_q <= seed_q;
		end else if (ctrl.draw_first || ctrl.draw_second) begin
			gen_q <= step;
		end
	end

	// item capture, bound set-up and draws
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q   <= cmd_t'(in_item.cmd);
			width_q <= in_item.width_sel;
			flip_q  <= flip_in;
			lo_q    <= (in_item.low_value & mask_in) ^ flip_in;
			hi_q    <= (cmd_t'(in_item.cmd) == CMD_CHANCE) ? in_item.chance_n
				: ((in_item.high_value & mask_in) ^ flip_in);
		end
		if (ctrl.setup) begin
			if (cmd_q == CMD_CHANCE) begin
				span_q    <= hi_q;
				swapped_q <= 1'b0;
			end else if (lo_q > hi_q) begin
				lo_q      <= hi_q;
				span_q    <= lo_q - hi_q;
				swapped_q <= (cmd_q == CMD_RANGE);
			end else begin
				span_q    <= hi_q - lo_q;
				swapped_q <= 1'b0;
			end
		end
		if (ctrl.bound) begin
			bound_q <= (cmd_q == CMD_CHANCE) ? span_q : span_q + 64'd1;
			full_q  <= (cmd_q == CMD_RANGE) && full;
			nzero_q <= (span_q == 64'd0);
		end
		if (ctrl.draw_first) begin
			v_q <= {32'd0, step};
		end else if (ctrl.draw_second) begin
			v_q <= {v_q[31:0], step};
		end
	end

	// restoring divider, one quotient bit a cycle, only the remainder kept
	assign trial = {rem_q, dvd_q[DW-1]};
	assign diff  = trial - {1'b0, bound_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.div_thr || ctrl.div_mod) begin
			cnt_q <= DIV_STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.div_thr) begin
			rem_q <= '0;
			dvd_q <= is64 ? neg_bound : {32'd0, neg_bound[31:0]};
		end else if (ctrl.div_mod) begin
			rem_q <= '0;
			dvd_q <= v_q;
		end else if (cnt_q != '0) begin
			rem_q <= diff[64] ? trial[63:0] : diff[63:0];
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
		end
	end

	// result assembly
	always_comb begin
		case (cmd_q)
			CMD_RAW:   res_value = v_q;
			CMD_RANGE: res_value = full_q ? v_q : lo_q + rem_q;
			default:   res_value = 64'd0;
		endcase
		res_value = (res_value & width_mask(width_q)) ^ flip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_q.value         <= res_value;
			out_q.chance_hit    <= (cmd_q == CMD_CHANCE) && (nzero_q || rem_q == 64'd0);
			out_q.range_swapped <= swapped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign stat.cmd      = cmd_q;
	assign stat.is64     = is64;
	assign stat.full     = full;
	assign stat.nzero    = (span_q == 64'd0);
	assign stat.div_busy = (cnt_q != '0);
	assign stat.v_ge_thr = (v_q >= rem_q);
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

[design/lcg_brg_ctrl.sv]
// ----------------------------------------------------------------------------
// lcg_brg_ctrl
// sequencer for set-up, draws, rejection loop and divider runs
// ----------------------------------------------------------------------------
module lcg_brg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lcg_brg_pkg::stat_t stat,
	output lcg_brg_pkg::ctrl_t ctrl
);
	import lcg_brg_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_nx = ST_SETUP;
			ST_SETUP:    state_nx = ST_BOUND;
			ST_BOUND: begin
				case (stat.cmd)
					CMD_RESTART: state_nx = ST_DONE;
					CMD_RAW:     state_nx = ST_RAW_A;
					CMD_RANGE:   state_nx = stat.full ? ST_RAW_A : ST_THR;
					default:     state_nx = stat.nzero ? ST_DONE : ST_THR;
				endcase
			end
			ST_RAW_A:    state_nx = stat.is64 ? ST_RAW_B : ST_DONE;
			ST_RAW_B:    state_nx = ST_DONE;
			ST_THR:      state_nx = ST_THR_WAIT;
			ST_THR_WAIT: if (!stat.div_busy) state_nx = ST_DRAW_A;
			ST_DRAW_A:   state_nx = stat.is64 ? ST_DRAW_B : ST_CHECK;
			ST_DRAW_B:   state_nx = ST_CHECK;
			ST_CHECK:    state_nx = stat.v_ge_thr ? ST_MOD_WAIT : ST_DRAW_A;
			ST_MOD_WAIT: if (!stat.div_busy) state_nx = ST_DONE;
			ST_DONE:     if (stat.out_free) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
			end
			ST_SETUP:  ctrl.setup = 1'b1;
			ST_BOUND: begin
				ctrl.bound   = 1'b1;
				ctrl.restart = (stat.cmd == CMD_RESTART);
			end
			ST_RAW_A, ST_DRAW_A: ctrl.draw_first = 1'b1;
			ST_RAW_B, ST_DRAW_B: ctrl.draw_second = 1'b1;
			ST_THR:    ctrl.div_thr = 1'b1;
			ST_CHECK:  ctrl.div_mod = stat.v_ge_thr;
			ST_DONE:   ctrl.out_load = stat.out_free;
			default:   ctrl = '0;
		endcase
	end

endmodule

[design/lcg_bounded_range_generator_unit.sv]
// ----------------------------------------------------------------------------
// lcg_bounded_range_generator_unit
// 32-bit lcg with raw, bounded-range and one-in-n chance draws
// ----------------------------------------------------------------------------
// one item is taken at a time and gives one result item. restart and a zero
// chance denominator skip the draws, and raw draws and full-span range draws
// skip the divider. range and chance draws run the bit-serial remainder unit
// twice, 64 steps each time: the threshold run after the set-up states, then
// the tries of the rejection loop, each retry drawing again, then the final
// modulo run and the result load. the divider sets the rate.
// the result sits in an output register, so the next item is taken while it
// waits. writing the seed also reloads the generator state; write it only
// while the unit is idle.
module lcg_bounded_range_generator_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	// item channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lcg_brg_pkg::in_item_t  in_item,
	// result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output lcg_brg_pkg::out_item_t out_item,
	// seed register
	input  logic                   cfg_we,
	input  logic [31:0]            cfg_wdata
);
	import lcg_brg_pkg::*;

	// command and status between sequencer and datapath
	ctrl_t ctrl;
	stat_t stat;

	lcg_brg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	lcg_brg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

endmodule

[dv/tb_lcg_bounded_range_generator_unit.sv]
// ----------------------------------------------------------------------------
// tb_lcg_bounded_range_generator_unit
// self-checking bench: directed table, receiver hold-off, then random commands;
// every result compared against an in-bench model of the lcg and its bounded draws
// ----------------------------------------------------------------------------
module tb_lcg_bounded_range_generator_unit;
	import lcg_brg_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	lcg_bounded_range_generator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// model copy of the seed register and generator
	logic [31:0] mdl_seed;
	logic [31:0] mdl_state;
	out_item_t   pending_results[$];
	int          errors;
	bit          hold_off_out;    // long receiver stall requested
	bit          no_idle;         // last part of the run, no gaps

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [31:0] lcg_step32();
		mdl_state = mdl_state * LCG_MUL + LCG_ADD;
		return mdl_state;
	endfunction

	function automatic logic [63:0] lcg_step64();
		logic [63:0] hi;
		logic [63:0] lo;
		hi = {32'd0, lcg_step32()};
		lo = {32'd0, lcg_step32()};
		return (hi << 32) | lo;
	endfunction

	function automatic logic [31:0] draw_below32(input logic [31:0] bound);
		logic [31:0] thr;
		logic [31:0] v;
		if (bound == 0) return lcg_step32();
		thr = (32'd0 - bound) % bound;
		forever begin
			v = lcg_step32();
			if (v >= thr) return v % bound;
		end
	endfunction

	function automatic logic [63:0] draw_below64(input logic [63:0] bound);
		logic [63:0] thr;
		logic [63:0] v;
		if (bound == 0) return lcg_step64();
		thr = (64'd0 - bound) % bound;
		forever begin
			v = lcg_step64();
			if (v >= thr) return v % bound;
		end
	endfunction

	// predicts the result of one command and advances the model generator
	function automatic out_item_t predict_draw(input in_item_t it);
		out_item_t r;
		logic [63:0] mask;
		logic [63:0] flip;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] t;
		logic [63:0] span;
		r = '0;
		mask = width_mask(it.width_sel);
		case (cmd_t'(it.cmd))
			CMD_RESTART: mdl_state = mdl_seed;
			CMD_RAW: begin
				if (it.width_sel == W64) r.value = lcg_step64();
				else r.value = {32'd0, lcg_step32()} & mask;
			end
			CMD_RANGE: begin
				flip = it.is_signed ? sign_bit(it.width_sel) : 64'd0;
				lo = (it.low_value & mask) ^ flip;
				hi = (it.high_value & mask) ^ flip;
				if (lo > hi) begin
					t = lo; lo = hi; hi = t;
					r.range_swapped = 1'b1;
				end
				span = hi - lo;
				if (it.width_sel == W64) begin
					if (span == '1) r.value = lcg_step64();
					else r.value = lo + draw_below64(span + 64'd1);
				end else if (it.width_sel == W32 && span == 64'hFFFF_FFFF) begin
					r.value = {32'd0, lcg_step32()};
				end else begin
					t = span + 64'd1;
					r.value = lo + {32'd0, draw_below32(t[31:0])};
				end
				r.value = (r.value & mask) ^ flip;
			end
			default: begin
				if (it.chance_n == 0) r.chance_hit = 1'b1;
				else r.chance_hit = (draw_below64(it.chance_n) == 0);
			end
		endcase
		return r;
	endfunction

	// directed rows; has_exp marks rows whose result is typed in
	typedef struct {
		in_item_t  it;
		bit        has_exp;
		out_item_t exp_res;
	} row_t;

	function automatic in_item_t mk(input cmd_t c, input width_t w, input logic s,
		input logic [63:0] lo, input logic [63:0] hi, input logic [63:0] n);
		in_item_t it;
		it.cmd = c; it.width_sel = w; it.is_signed = s;
		it.low_value = lo; it.high_value = hi; it.chance_n = n;
		return it;
	endfunction

	// random command; chance denominators are often small so draws stay short
	function automatic in_item_t rand_item();
		in_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.width_sel = 2'($urandom_range(0, 3));
		it.is_signed = 1'($urandom_range(0, 1));
		it.low_value = {$urandom, $urandom};
		it.high_value = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: it.low_value = it.high_value;
			1: begin
				it.low_value = '0; it.high_value = '1;
			end
			2: it.high_value = it.low_value + 64'($urandom_range(0, 40));
			default: ;
		endcase
		case ($urandom_range(0, 4))
			0: it.chance_n = '0;
			1: it.chance_n = {$urandom, $urandom};
			2: it.chance_n = '1;
			default: it.chance_n = 64'($urandom_range(1, 8));
		endcase
		return it;
	endfunction

	// offers one item, with a random gap first; valid drops only for a gap
	task automatic send_item(input in_item_t it);
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results.push_back(predict_draw(it));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] s);
		cfg_we    <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mdl_seed  = s;
		mdl_state = s;
	endtask

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_out) out_ready <= 1'b0;
			else if (!no_idle && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16) - 1) @(posedge clk);
			end else out_ready <= 1'b1;
		end
	end

	// checker: every accepted result against the oldest prediction
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no prediction waiting");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_item.value !== e.value) begin
					$error("value: expected %h actual %h", e.value, out_item.value);
					errors++;
				end
				if (out_item.chance_hit !== e.chance_hit) begin
					$error("chance_hit: expected %b actual %b", e.chance_hit,
						out_item.chance_hit);
					errors++;
				end
				if (out_item.range_swapped !== e.range_swapped) begin
					$error("range_swapped: expected %b actual %b", e.range_swapped,
						out_item.range_swapped);
					errors++;
				end
			end
		end
	end

	row_t rows[$];
	row_t rw;
	out_item_t got;
	int n;
	int k;
	logic [31:0] seeds[4];

	initial begin
		errors = 0;
		hold_off_out = 0;
		no_idle = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		mdl_seed = '0;
		mdl_state = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed results: reset-state raw draw, n zero, restart, raw draw after it, equal bounds
		rw.has_exp = 1; rw.exp_res = '0;
		rw.it = mk(CMD_RAW, W32, 0, 0, 0, 0);
		rw.exp_res.value = 64'd1013904223;      // first step from state zero
		rows.push_back(rw);
		rw.it = mk(CMD_CHANCE, W8, 0, 0, 0, 0);
		rw.exp_res = '0; rw.exp_res.chance_hit = 1;
		rows.push_back(rw);
		rw.it = mk(CMD_RESTART, W64, 1, '1, '1, '1);
		rw.exp_res = '0;
		rows.push_back(rw);
		rw.it = mk(CMD_RAW, W8, 0, 0, 0, 0);
		rw.exp_res.value = 64'h5F;              // low byte of first step again
		rows.push_back(rw);
		rw.has_exp = 0;
		rows.push_back('{mk(CMD_RAW, W16, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(CMD_RAW, W64, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W8, 0, 0, 8'hFF, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W8, 1, 8'h80, 8'h7F, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W16, 0, 16'hFFFF, 0, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W16, 1, 16'h0005, 16'hFFFB, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W32, 0, 0, 32'hFFFF_FFFF, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W32, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W64, 0, 0, '1, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W64, 1, 64'h8000_0000_0000_0000,
			64'h7FFF_FFFF_FFFF_FFFF, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W64, 0, '1, 64'h1, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W32, 0, 64'hFFFF_FFFF_0000_0003,
			64'hAAAA_5555_0000_0010, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W32, 0, 32'h1, 32'h8000_0001, 0), 0, '0});
		rows.push_back('{mk(CMD_RANGE, W64, 0, 0, 64'h8000_0000_0000_0000, 0), 0, '0});
		rows.push_back('{mk(CMD_CHANCE, W8, 0, 0, 0, 1), 0, '0});
		rows.push_back('{mk(CMD_CHANCE, W64, 1, '1, '1, '1), 0, '0});
		rows.push_back('{mk(CMD_CHANCE, W8, 0, 0, 0, 64'h8000_0000_0000_0001), 0, '0});
		// equal bounds: nothing to choose, value is the bound itself
		rw.has_exp = 1; rw.exp_res = '0;
		rw.it = mk(CMD_RANGE, W16, 0, 16'h1234, 16'h1234, 0);
		rw.exp_res.value = 64'h1234;
		rows.push_back(rw);

		foreach (rows[i]) begin
			send_item(rows[i].it);
			if (rows[i].has_exp) begin
				got = pending_results[$];
				if (got !== rows[i].exp_res) begin
					$error("row %0d: expected %h model %h", i, rows[i].exp_res, got);
					errors++;
				end
			end
		end
		wait_drained();

		// receiver held off long while items keep coming
		hold_off_out = 1;
		fork
			begin
				for (k = 0; k < 10; k++) send_item(mk(CMD_RAW, W8, 0, 0, 0, 0));
			end
			begin
				repeat (400) @(posedge clk);
				hold_off_out = 0;
			end
		join
		wait_drained();

		// random phases over several seeds, extremes among them
		seeds[0] = 32'hFFFF_FFFF; seeds[1] = 32'h0; seeds[2] = $urandom;
		seeds[3] = $urandom;
		for (int ph = 0; ph < 4; ph++) begin
			write_seed(seeds[ph]);
			for (n = 0; n < 180; n++) begin
				if (ph == 3 && n >= 130) no_idle = 1;
				send_item(rand_item());
			end
			// sender waits for every result before the next seed write
			wait_drained();
		end

		if (errors == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
design/lcg_brg_pkg.sv
design/lcg_brg_datapath.sv
design/lcg_brg_ctrl.sv
design/lcg_bounded_range_generator_unit.sv
dv/tb_lcg_bounded_range_generator_unit.sv
